// ===== rtl/swmm_pkg.sv =====
// Shared types and constants for the sliding window minimum/maximum block.
// Depends on nothing; the controller, datapath, top level and checker import it.
package swmm_pkg;

	// Default sizing of the block.
	localparam int SWMM_WINDOW_MAX  = 64;
	localparam int SWMM_SAMPLE_BITS = 16;

	// Width of the window length register.
	localparam int SWMM_LEN_BITS = 7;

	// Controller states: one item walks IDLE -> DROP -> APPEND -> EMIT.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DROP,
		ST_APPEND,
		ST_EMIT
	} swmm_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic drop;
		logic append;
		logic load;
	} swmm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic out_busy;
	} swmm_stat_t;

endpackage

// ===== rtl/swmm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module swmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/swmm_queue.sv =====
// Monotonic queue as a row of cells: every cell compares itself with the new value
// in parallel, and a head drop shifts the whole row down by one. Depends on nothing.
// The head holds the largest value; feed inverted samples to track the smallest.
module swmm_queue #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    drop_en,
	input  logic signed [WIDTH-1:0] leaving,
	input  logic                    append_en,
	input  logic signed [WIDTH-1:0] din,
	output logic signed [WIDTH-1:0] head
);

	logic signed [WIDTH-1:0] cell_q [DEPTH];
	logic [DEPTH-1:0]        valid_q;
	logic signed [WIDTH-1:0] up_cell [DEPTH];
	logic [DEPTH-1:0]        up_valid;
	logic [DEPTH-1:0]        keep;
	logic [DEPTH-1:0]        insert;
	logic                    drop_do;

	// The head leaves only when it equals the sample that leaves the window.
	assign drop_do = drop_en && valid_q[0] && (cell_q[0] == leaving);
	assign head    = cell_q[0];

	genvar i;
	for (i = 0; i < DEPTH; i++) begin : g_cell
		// A cell stays when it is occupied and not smaller than the new value.
		assign keep[i] = valid_q[i] && !(din > cell_q[i]);

		// The new value lands in the first cell that is not kept; a full row
		// overwrites its last cell.
		if (i == 0) begin : g_first
			assign insert[i] = !keep[i];
		end else if (i == DEPTH - 1) begin : g_last_ins
			assign insert[i] = keep[i-1];
		end else begin : g_mid_ins
			assign insert[i] = keep[i-1] && !keep[i];
		end

		// Neighbor that moves in on a head drop.
		if (i < DEPTH - 1) begin : g_mid_up
			assign up_cell[i]  = cell_q[i+1];
			assign up_valid[i] = valid_q[i+1];
		end else begin : g_last_up
			assign up_cell[i]  = cell_q[i];
			assign up_valid[i] = 1'b0;
		end

		// Cell payload.
		always_ff @(posedge clk) begin
			if (drop_do) begin
				cell_q[i] <= up_cell[i];
			end else if (append_en && insert[i]) begin
				cell_q[i] <= din;
			end
		end
	end

	// Occupancy bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (drop_do) begin
			valid_q <= up_valid;
		end else if (append_en) begin
			valid_q <= keep | insert;
		end
	end

endmodule

// ===== rtl/swmm_ctrl.sv =====
// Controller state machine: sequences one item through drop, append and emit.
// Depends on swmm_pkg.
module swmm_ctrl import swmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  swmm_stat_t stat,
	output swmm_cmd_t  cmd
);

	swmm_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				cmd.drop = stat.full;
				state_d  = ST_APPEND;
			end
			ST_APPEND: begin
				cmd.append = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (!stat.full) begin
					state_d = ST_IDLE;
				end else if (!stat.out_busy) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/swmm_datapath.sv =====
// Datapath: window length register, history ring, both monotonic queues and the
// output register. Depends on swmm_pkg, swmm_ram and swmm_queue.
module swmm_datapath import swmm_pkg::*; #(
	parameter int WINDOW_MAX  = SWMM_WINDOW_MAX,
	parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [SWMM_LEN_BITS-1:0]      cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          start_req,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS-1:0] window_min,
	input  swmm_cmd_t                     cmd,
	output swmm_stat_t                    stat
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int LW = $clog2(WINDOW_MAX + 1);
	localparam int SW = LW + 1;

	logic [LW-1:0]                 len_q, len_d;
	logic [AW-1:0]                 slot_q;
	logic [LW-1:0]                 fill_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic                          clear;
	logic [SW-1:0]                 slot_x, len_x, old_x;
	logic [AW-1:0]                 old_addr;
	logic signed [SAMPLE_BITS-1:0] leaving;
	logic signed [SAMPLE_BITS-1:0] fall_head, rise_head;
	logic                          out_valid_q;

	// Effective window length: zero counts as one, large values saturate.
	always_comb begin
		if (cfg_data == '0) begin
			len_d = LW'(1);
		end else if (32'(cfg_data) > 32'(WINDOW_MAX)) begin
			len_d = LW'(WINDOW_MAX);
		end else begin
			len_d = LW'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LW'(1);
		end else if (cfg_write) begin
			len_q <= len_d;
		end
	end

	// A start request or a new window length restarts the stream.
	assign clear = cfg_write || (cmd.accept && start_req);

	// Write slot and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (clear) begin
			slot_q <= '0;
			fill_q <= '0;
		end else if (cmd.append) begin
			slot_q <= (32'(slot_q) == WINDOW_MAX - 1) ? '0 : slot_q + AW'(1);
			if (fill_q < len_q) begin
				fill_q <= fill_q + LW'(1);
			end
		end
	end

	assign stat.full     = (fill_q >= len_q);
	assign stat.out_busy = out_valid_q && !out_ready;

	// Sample held for the rest of the item.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			sample_q <= sample;
		end
	end

	// Slot of the sample that leaves the window, read at the input transfer.
	assign slot_x   = SW'(slot_q);
	assign len_x    = SW'(len_q);
	assign old_x    = (slot_x >= len_x) ? (slot_x - len_x)
	                                    : (slot_x + SW'(WINDOW_MAX) - len_x);
	assign old_addr = AW'(old_x);

	swmm_ram #(
		.WIDTH(SAMPLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_ring (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(slot_q),
		.wdata(sample_q),
		.raddr(old_addr),
		.rdata(leaving)
	);

	// Falling queue tracks the maximum.
	swmm_queue #(
		.DEPTH(WINDOW_MAX),
		.WIDTH(SAMPLE_BITS)
	) u_fall (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.drop_en  (cmd.drop),
		.leaving  (leaving),
		.append_en(cmd.append),
		.din      (sample_q),
		.head     (fall_head)
	);

	// Rising queue works on inverted samples, which reverses the signed order.
	swmm_queue #(
		.DEPTH(WINDOW_MAX),
		.WIDTH(SAMPLE_BITS)
	) u_rise (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.drop_en  (cmd.drop),
		.leaving  (~leaving),
		.append_en(cmd.append),
		.din      (~sample_q),
		.head     (rise_head)
	);

	// Output register and its valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			window_max <= fall_head;
			window_min <= ~rise_head;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sliding_window_min_max_core.sv =====
// Sliding window minimum and maximum: top level joining controller and datapath.
// Depends on swmm_pkg, swmm_ctrl and swmm_datapath.
//
// Usage:
//   cfg channel: a transfer writes window_len (zero acts as one, values above
//     WINDOW_MAX act as WINDOW_MAX) and restarts the stream. Write it only
//     while the block is idle.
//   in channel: one signed sample per transfer; start_req set clears the
//     window and both queues before that sample is taken.
//   out channel: once the window holds window_len samples, every input gives
//     one result with the window maximum and minimum; before that, none.
// Timing: an item walks four steps: input transfer with history read, head
//   drop, append into both queues and history write, output load. The result
//   is offered from the output register once loaded. The controller walks one
//   item at a time, so a new sample is taken only when the last one is done.
// Stalls: the output register holds a result until taken; the next item may
//   enter meanwhile and waits in its last step only if its own result is due.
// Reset: window_len returns to one, the stream is empty and out_valid is low.
module sliding_window_min_max_core import swmm_pkg::*; #(
	parameter int WINDOW_MAX  = SWMM_WINDOW_MAX,
	parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [SWMM_LEN_BITS-1:0]      cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          start_req,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] window_max,
	output logic signed [SAMPLE_BITS-1:0] window_min
);

	swmm_cmd_t  cmd;
	swmm_stat_t stat;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	swmm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	swmm_datapath #(
		.WINDOW_MAX (WINDOW_MAX),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.start_req (start_req),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.window_max(window_max),
		.window_min(window_min),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== rtl/swmm_checker.sv =====
// Port-level checks for the sliding window minimum/maximum top level, with the
// bind that attaches them. Depends on swmm_pkg and sliding_window_min_max_core.
module swmm_checker import swmm_pkg::*; #(
	parameter int SAMPLE_BITS = SWMM_SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] window_max,
	input logic signed [SAMPLE_BITS-1:0] window_min
);

	// A stalled result keeps its valid and its values.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(window_max) &&
		$stable(window_min)))
		else $error("stalled result changed");

	// One item at a time: after an input transfer the input side closes.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in flight");

	// The maximum of a window is never below its minimum.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (window_max >= window_min))
		else $error("window maximum below minimum");

	// A fresh result follows an input transfer that went through the drop, append and load steps.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("result without a matching input transfer");

endmodule

bind sliding_window_min_max_core swmm_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_swmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.window_max(window_max),
	.window_min(window_min)
);

// ===== dv/sliding_window_min_max_core_test.sv =====
// Self-checking testbench for sliding_window_min_max_core: a behavioral window model
// predicts every window maximum and minimum and a monitor compares each output transfer.
// Depends on swmm_pkg and the block's RTL only.
module sliding_window_min_max_core_test;
	import swmm_pkg::*;

	typedef logic signed [SWMM_SAMPLE_BITS-1:0] sample_t;
	typedef logic [SWMM_LEN_BITS-1:0] len_t;

	typedef struct packed {
		sample_t max_v;
		sample_t min_v;
	} extremes_t;

	localparam int CYCLE_LIMIT   = 800000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_ITEMS   = 115;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    cfg_valid;
	logic    cfg_ready;
	len_t    cfg_data;
	logic    in_valid;
	logic    in_ready;
	sample_t sample;
	logic    start_req;
	logic    out_valid;
	logic    out_ready;
	sample_t window_max;
	sample_t window_min;

	// Window model: history ring, both monotonic queues and the length register.
	sample_t     history[SWMM_WINDOW_MAX];
	int unsigned slot_ptr;
	int unsigned filled;
	sample_t     desc_q[$];
	sample_t     asc_q[$];
	len_t        len_reg;

	// Expected extremes in output order.
	extremes_t pending_extremes[$];

	bit no_idle;
	int fail_count;
	int results_checked;
	int samples_sent;
	int settings_count;
	int cycle_count;

	sliding_window_min_max_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.start_req  (start_req),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_max (window_max),
		.window_min (window_min)
	);

	always #6 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Length actually used: zero acts as one, large values saturate.
	function automatic int unsigned effective_len();
		if (len_reg == 0)
			return 1;
		if (len_reg > SWMM_WINDOW_MAX)
			return SWMM_WINDOW_MAX;
		return 32'(len_reg);
	endfunction

	function automatic void restart_window();
		slot_ptr = 0;
		filled = 0;
		desc_q.delete();
		asc_q.delete();
	endfunction

	// Advance the window model by one sample and queue the extremes it yields.
	function automatic void predict_extremes(input sample_t s, input logic restart);
		int unsigned len;
		sample_t leaving;
		extremes_t result;
		len = effective_len();
		if (restart)
			restart_window();
		// The oldest sample leaves a full window; it only matters if it heads a queue.
		if (filled >= len) begin
			leaving = history[(slot_ptr + SWMM_WINDOW_MAX - len) % SWMM_WINDOW_MAX];
			if (desc_q.size() > 0 && desc_q[0] == leaving)
				desc_q.delete(0);
			if (asc_q.size() > 0 && asc_q[0] == leaving)
				asc_q.delete(0);
		end
		// Drop tail entries that the new sample dominates, then append it.
		while (desc_q.size() > 0 && s > desc_q[$])
			desc_q.delete(desc_q.size() - 1);
		desc_q.insert(desc_q.size(), s);
		while (asc_q.size() > 0 && s < asc_q[$])
			asc_q.delete(asc_q.size() - 1);
		asc_q.insert(asc_q.size(), s);
		history[slot_ptr] = s;
		slot_ptr = (slot_ptr + 1) % SWMM_WINDOW_MAX;
		if (filled < len)
			filled++;
		if (filled >= len) begin
			result.max_v = desc_q[0];
			result.min_v = asc_q[0];
			pending_extremes.insert(pending_extremes.size(), result);
		end
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int unsigned idle_cycles();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	// Mix of full-range values, the two extremes and a narrow band that repeats values.
	function automatic sample_t random_sample();
		int v;
		case ($urandom_range(0, 9))
			0: return {1'b0, {(SWMM_SAMPLE_BITS-1){1'b1}}};
			1: return {1'b1, {(SWMM_SAMPLE_BITS-1){1'b0}}};
			2, 3, 4: begin
				v = $urandom_range(0, 8);
				return sample_t'(v - 4);
			end
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Receiver: random stalls on the output channel.
	initial begin
		int unsigned n;
		out_ready <= 1'b0;
		@(posedge clk);
		forever begin
			n = idle_cycles();
			if (n == 0) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Compare every output transfer with the oldest expectation.
	always @(posedge clk) begin
		extremes_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_extremes.size() == 0) begin
				$error("unexpected result: window_max %0d, window_min %0d",
					window_max, window_min);
				fail_count++;
			end else begin
				e = pending_extremes[0];
				pending_extremes.delete(0);
				results_checked++;
				if (window_max !== e.max_v) begin
					$error("window_max: expected %0d, got %0d", e.max_v, window_max);
					fail_count++;
				end
				if (window_min !== e.min_v) begin
					$error("window_min: expected %0d, got %0d", e.min_v, window_min);
					fail_count++;
				end
			end
		end
	end

	// Offer one sample after a random gap and wait for its transfer.
	task automatic send_sample(input sample_t s, input logic restart);
		int unsigned gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		start_req <= restart;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_extremes(s, restart);
		samples_sent++;
	endtask

	// Hold the input off until every expected result is out and the pipeline is empty.
	task automatic wait_until_idle();
		in_valid <= 1'b0;
		while (pending_extremes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write window_len while the block is idle; the stream restarts.
	task automatic write_window_len(input len_t value);
		wait_until_idle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		len_reg = value;
		restart_window();
		settings_count++;
	endtask

	// Reset length of one: every sample is its own maximum and minimum.
	task automatic test_default_window();
		send_sample({1'b0, {(SWMM_SAMPLE_BITS-1){1'b1}}}, 1'b0);
		send_sample({1'b1, {(SWMM_SAMPLE_BITS-1){1'b0}}}, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
	endtask

	// No result while filling; equal values leave the queue heads one at a time.
	task automatic test_filling_and_duplicates();
		write_window_len(len_t'(3));
		send_sample(sample_t'(5), 1'b0);
		send_sample(sample_t'(5), 1'b0);
		send_sample(sample_t'(5), 1'b0);
		send_sample(sample_t'(7), 1'b0);
		send_sample(sample_t'(-2), 1'b0);
		send_sample(sample_t'(5), 1'b0);
		send_sample(sample_t'(5), 1'b0);
	endtask

	// A start request empties the window before its own sample is taken.
	task automatic test_start_clears_stream();
		write_window_len(len_t'(4));
		send_sample(sample_t'(10), 1'b0);
		send_sample(sample_t'(-20), 1'b0);
		send_sample(sample_t'(30), 1'b0);
		send_sample(sample_t'(-40), 1'b0);
		send_sample(sample_t'(50), 1'b1);
		send_sample(sample_t'(1), 1'b0);
		send_sample(sample_t'(2), 1'b0);
		send_sample(sample_t'(3), 1'b0);
	endtask

	// A length of zero behaves as a length of one.
	task automatic test_zero_length();
		write_window_len(len_t'(0));
		send_sample(sample_t'(-7), 1'b0);
		send_sample(sample_t'(9), 1'b0);
		send_sample(sample_t'(-7), 1'b0);
	endtask

	// Rewriting the same length still restarts the stream.
	task automatic test_config_restart();
		write_window_len(len_t'(2));
		send_sample(sample_t'(100), 1'b0);
		send_sample(sample_t'(-100), 1'b0);
		send_sample(sample_t'(0), 1'b0);
		write_window_len(len_t'(2));
		send_sample(sample_t'(42), 1'b0);
		send_sample(sample_t'(-42), 1'b0);
	endtask

	// Random streams over a series of lengths, including the saturating ones.
	task automatic test_random_windows();
		len_t lengths[8] = '{1, 2, 64, 127, 0, 5, 65, 16};
		len_t len_value;
		int unsigned restart_odds;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			len_value = (phase < 8) ? lengths[phase] : len_t'($urandom_range(0, 127));
			write_window_len(len_value);
			no_idle = (phase % 3 == 2);
			// Restarts are rarer for long windows so that results keep coming.
			restart_odds = 4 * effective_len() + 20;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i == PHASE_ITEMS / 2)
					wait_until_idle();
				send_sample(random_sample(), $urandom_range(0, restart_odds) == 0);
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		sample <= '0;
		start_req <= 1'b0;
		len_reg = len_t'(1);
		restart_window();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_window();
		test_filling_and_duplicates();
		test_start_clears_stream();
		test_zero_length();
		test_config_restart();
		test_random_windows();
		wait_until_idle();

		$display("Sent %0d samples under %0d window_len writes; %0d results compared.",
			samples_sent, settings_count, results_checked);
		$display("Lengths ranged from zero through saturation, with restarts and stalls.");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
